/* sv/ets_pkg.sv */
`timescale 1ns / 1ps

package ets_pkg;

  // field widths
  localparam int SecW  = 33;
  localparam int DayW  = 17;
  localparam int TodW  = 17;
  localparam int YearW = 12;

  // calendar constants
  localparam logic [YearW-1:0] BaseYear    = 12'd1904;
  localparam logic [2:0]       BaseWeekday = 3'd4;
  localparam logic [DayW-1:0]  LimitDays   = 17'd71589;
  localparam logic [10:0]      CycleDays   = 11'd1461;
  localparam logic [10:0]      LeapDays    = 11'd366;
  localparam logic [10:0]      PlainDays   = 11'd365;

  // reciprocals for division by constants, exact over the ranges used here
  // seconds are split as 86400 = 128 * 675
  localparam int               Sh675  = 36;
  localparam logic [26:0]      Rcp675 = 27'd101806633;
  localparam logic [9:0]       Div675 = 10'd675;
  localparam int               Sh1461  = 28;
  localparam logic [17:0]      Rcp1461 = 18'd183735;
  localparam int               Sh7  = 21;
  localparam logic [18:0]      Rcp7 = 19'd299594;
  localparam int               Sh60  = 24;
  localparam logic [18:0]      Rcp60 = 19'd279621;

  // month start days, plain and leap years
  localparam logic [8:0] PLAIN_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] LEAP_START [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  // day count and time of day after the split
  typedef struct packed {
    logic            valid;
    logic [DayW-1:0] days;
    logic [TodW-1:0] tod;
  } ets_split_t;

  // date fields at the end of the pipeline
  typedef struct packed {
    logic             valid;
    logic             out_of_range;
    logic [2:0]       weekday;
    logic [3:0]       month;
    logic [4:0]       day_of_month;
    logic [YearW-1:0] year;
  } ets_date_t;

  // time of day fields
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } ets_time_t;

  // index 0..11 of the last month that starts on or before doy
  function automatic logic [3:0] month_index(input logic [8:0] doy, input logic leap);
    logic [3:0] idx;
    logic [8:0] st;
    idx = 4'd0;
    for (int i = 1; i < 12; i++) begin
      st = leap ? LEAP_START[i] : PLAIN_START[i];
      if (st <= doy) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* sv/ets_split.sv */
`timescale 1ns / 1ps

module ets_split import ets_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [SecW-1:0] secs,
  output ets_split_t      split
);

  logic             v1;
  logic [25:0]      x1;
  logic [6:0]       lo1;
  logic [DayW-1:0]  days1;
  logic [52:0]      day_prod;
  logic [25:0]      rem_full;

  // seconds / 128 / 675 by reciprocal
  assign day_prod = 53'(secs[SecW-1:7]) * 53'(Rcp675);

  // stage 1: whole days
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x1    <= secs[SecW-1:7];
    lo1   <= secs[6:0];
    days1 <= day_prod[52:Sh675];
  end

  // remainder of the 675 division, rejoined with the low seven bits
  assign rem_full = x1 - 26'(days1) * 26'(Div675);

  // stage 2: days and time of day
  always_ff @(posedge clk) begin
    if (rst) begin
      split.valid <= 1'b0;
    end else begin
      split.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    split.days <= days1;
    split.tod  <= {rem_full[9:0], lo1};
  end

endmodule

/* sv/ets_clock.sv */
`timescale 1ns / 1ps

module ets_clock import ets_pkg::*; (
  input  logic       clk,
  input  ets_split_t split,
  output ets_time_t  tm
);

  logic [35:0]      q60_prod;
  logic [TodW-1:0]  tod_a;
  logic [10:0]      q60_a;
  logic [TodW-1:0]  sec_full;
  logic [29:0]      hr_prod;
  logic [10:0]      q60_b;
  logic [5:0]       sec_b;
  logic [4:0]       hr_b;
  logic [10:0]      min_full;
  ets_time_t        tm_c;

  // stage a: total minutes of the day
  assign q60_prod = 36'(split.tod) * 36'(Rcp60);

  always_ff @(posedge clk) begin
    tod_a <= split.tod;
    q60_a <= q60_prod[34:Sh60];
  end

  // stage b: seconds and hours
  assign sec_full = tod_a - 17'(q60_a) * 17'd60;
  assign hr_prod  = 30'(q60_a) * 30'(Rcp60);

  always_ff @(posedge clk) begin
    q60_b <= q60_a;
    sec_b <= sec_full[5:0];
    hr_b  <= hr_prod[28:Sh60];
  end

  // stage c: minutes within the hour
  assign min_full = q60_b - 11'(hr_b) * 11'd60;

  always_ff @(posedge clk) begin
    tm_c.hour   <= hr_b;
    tm_c.minute <= min_full[5:0];
    tm_c.second <= sec_b;
  end

  // stage d: aligned with the date output
  always_ff @(posedge clk) begin
    tm <= tm_c;
  end

endmodule

/* sv/ets_date.sv */
`timescale 1ns / 1ps

module ets_date import ets_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ets_split_t split,
  output ets_date_t  date
);

  logic             va, vb, vc;
  logic [34:0]      cyc_prod;
  logic [36:0]      wk_prod;
  logic [DayW:0]    days_wk;
  logic [DayW-1:0]  days_a;
  logic [DayW:0]    wk_a;
  logic [6:0]       cyc_a;
  logic [15:0]      wq_a;
  logic [DayW-1:0]  rem_full;
  logic [DayW:0]    wd_full;
  logic [10:0]      rem_b;
  logic [6:0]       cyc_b;
  logic [2:0]       wd_b;
  logic             oor_b;
  logic [10:0]      rest;
  logic             leap_n;
  logic [1:0]       yoff_n;
  logic [8:0]       doy_n;
  logic             leap_c;
  logic [8:0]       doy_c;
  logic [YearW-1:0] year_c;
  logic [2:0]       wd_c;
  logic             oor_c;
  logic [3:0]       midx;
  logic [8:0]       mstart;
  logic [8:0]       dom_full;

  // stage a: four-year cycles and weeks by reciprocal
  assign days_wk  = 18'(split.days) + 18'(BaseWeekday);
  assign cyc_prod = 35'(split.days) * 35'(Rcp1461);
  assign wk_prod  = 37'(days_wk) * 37'(Rcp7);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= split.valid;
    end
  end

  always_ff @(posedge clk) begin
    days_a <= split.days;
    wk_a   <= days_wk;
    cyc_a  <= cyc_prod[34:Sh1461];
    wq_a   <= wk_prod[36:Sh7];
  end

  // stage b: day within the cycle, weekday, range check
  assign rem_full = days_a - 17'(cyc_a) * 17'(CycleDays);
  assign wd_full  = wk_a - 18'(wq_a) * 18'd7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    rem_b <= rem_full[10:0];
    cyc_b <= cyc_a;
    wd_b  <= wd_full[2:0];
    oor_b <= (days_a >= LimitDays);
  end

  // year within the cycle: the first year is the leap one
  assign rest = rem_b - LeapDays;

  always_comb begin
    leap_n = 1'b0;
    yoff_n = 2'd1;
    doy_n  = 9'd0;
    priority if (rem_b < LeapDays) begin
      leap_n = 1'b1;
      yoff_n = 2'd0;
      doy_n  = rem_b[8:0];
    end else if (rest < PlainDays) begin
      yoff_n = 2'd1;
      doy_n  = rest[8:0];
    end else if (rest < 11'(2 * PlainDays)) begin
      yoff_n = 2'd2;
      doy_n  = 9'(rest - PlainDays);
    end else begin
      yoff_n = 2'd3;
      doy_n  = 9'(rest - 11'(2 * PlainDays));
    end
  end

  // stage c: year and day of year
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    leap_c <= leap_n;
    doy_c  <= doy_n;
    year_c <= BaseYear + {3'b000, cyc_b, 2'b00} + 12'(yoff_n);
    wd_c   <= wd_b;
    oor_c  <= oor_b;
  end

  // month lookup over the start table
  assign midx     = month_index(doy_c, leap_c);
  assign mstart   = leap_c ? LEAP_START[midx] : PLAIN_START[midx];
  assign dom_full = doy_c - mstart + 9'd1;

  // stage d: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      date.valid <= 1'b0;
    end else begin
      date.valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    date.out_of_range <= oor_c;
    date.weekday      <= wd_c;
    date.month        <= midx + 4'd1;
    date.day_of_month <= dom_full[4:0];
    date.year         <= year_c;
  end

endmodule

/* sv/epoch_seconds_to_calendar.sv */
`timescale 1ns / 1ps
// channel   | signals                                   | transfer
// ----------+-------------------------------------------+------------------------------
// command   | start, busy, epoch_seconds                | edge with start high, busy low
// result    | done, weekday, month, day_of_month, hour, | edge that ends the done cycle
//           | minute, second, year, out_of_range        |
//
// one conversion enters every cycle; busy is always low
// a result leaves once its command has passed the six register
// stages: day split (two), then the calendar and clock pipelines (four)
// rst clears the valid bits of every stage; data registers are not reset
// the receiver cannot stall, so the pipeline never holds
module epoch_seconds_to_calendar import ets_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [SecW-1:0]  epoch_seconds,
  output logic             done,
  output logic [2:0]       weekday,
  output logic [3:0]       month,
  output logic [4:0]       day_of_month,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic [YearW-1:0] year,
  output logic             out_of_range
);

  ets_split_t split;
  ets_date_t  date;
  ets_time_t  tm;
  logic       ok;

  assign busy = 1'b0;

  // seconds into days and time of day
  ets_split u_split (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .secs     (epoch_seconds),
    .split    (split)
  );

  // calendar date
  ets_date u_date (
    .clk   (clk),
    .rst   (rst),
    .split (split),
    .date  (date)
  );

  // time of day
  ets_clock u_clock (
    .clk   (clk),
    .split (split),
    .tm    (tm)
  );

  // fields read as zero past the calendar range
  assign ok           = !date.out_of_range;
  assign done         = date.valid;
  assign out_of_range = date.out_of_range;
  assign weekday      = ok ? date.weekday      : 3'd0;
  assign month        = ok ? date.month        : 4'd0;
  assign day_of_month = ok ? date.day_of_month : 5'd0;
  assign year         = ok ? date.year         : '0;
  assign hour         = ok ? tm.hour           : 5'd0;
  assign minute       = ok ? tm.minute         : 6'd0;
  assign second       = ok ? tm.second         : 6'd0;

  // every command yields a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##6 done)
    else $error("missing result for a command");

  // no result without a command
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !start |-> ##6 !done)
    else $error("result without a command");

  // date fields stay in the calendar
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (done && !out_of_range) |-> (year >= 12'd1904 && year <= 12'd2099 &&
      month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1 && weekday <= 3'd6))
    else $error("date field out of range");

  // time fields stay in the day
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (done && !out_of_range) |-> (hour < 5'd24 && minute < 6'd60 && second < 6'd60))
    else $error("time field out of range");

  // february fits its leap rule
  a_february: assert property (@(posedge clk) disable iff (rst)
    (done && !out_of_range && month == 4'd2) |->
      (day_of_month <= 5'd29 && (year[1:0] == 2'b00 || day_of_month <= 5'd28)))
    else $error("february day out of range");

endmodule
